>>> hw/rtl/assert_macros.svh
// assertion macros used by the top rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// condition that holds at every clock edge outside reset
`define BNWT_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// same-cycle implication outside reset
`define BNWT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define BNWT_ASSERT(lbl, cond, msg)
`define BNWT_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/bnwt_pkg.sv
// package: constants, codes and types of the brace nested word tokenizer
package bnwt_pkg;

	// limits
	localparam int MAX_LINE_LEN   = 1024;
	localparam int MAX_NEST_DEPTH = 255;
	localparam int POS_MAX        = 2047;
	localparam int LEN_MAX        = 1023;

	// field widths
	localparam int CHAR_W  = 8;
	localparam int BASE_W  = 10;
	localparam int POS_W   = 11;
	localparam int LEN_W   = 10;
	localparam int KIND_W  = 3;
	localparam int DEPTH_W = 8;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// scan modes
	localparam logic [1:0] MODE_BETWEEN = 2'd0;
	localparam logic [1:0] MODE_BARE    = 2'd1;
	localparam logic [1:0] MODE_BRACED  = 2'd2;
	localparam logic [1:0] MODE_DROP    = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_WORD  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OK    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BRACE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_END   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_LONG  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DEEP  = 3'd5;

	// characters
	localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

	// one result word
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic              last;
	} res_t;

	// results pushed by the scanner in one cycle
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

>>> hw/rtl/bnwt_scan.sv
// scanner: input register, line state and per-byte result logic
module bnwt_scan import bnwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [CHAR_W-1:0] char_byte,
	input  logic              end_of_line,
	input  logic [BASE_W-1:0] base_offset,
	input  logic              room,
	output push_t             push
);

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eol_s1;
	logic [BASE_W-1:0] base_s1;

	// line state
	logic [1:0]         mode_q;
	logic [POS_W-1:0]   cp_q;
	logic [POS_W-1:0]   ws_q;
	logic [DEPTH_W-1:0] nd_q;
	logic [BASE_W-1:0]  lbase_q;
	logic               start_q;

	logic fire;
	logic accept;

	// state as seen by the current byte, after a new line is opened
	logic [1:0]         md;
	logic [POS_W-1:0]   cp;
	logic [POS_W-1:0]   ws;
	logic [DEPTH_W-1:0] nd;
	logic [BASE_W-1:0]  base;

	logic [POS_W:0]     abs_cp;
	logic [POS_W-1:0]   abs_ws;
	logic [POS_W-1:0]   wlen;
	logic               long_word;
	logic               is_space;
	logic               too_long;
	res_t               word_res;
	res_t               r0;
	res_t               r1;
	logic [1:0]         n;

	logic [1:0]         mode_d;
	logic [POS_W-1:0]   cp_d;
	logic [POS_W-1:0]   ws_d;
	logic [DEPTH_W-1:0] nd_d;
	logic               start_d;
	logic [DEPTH_W-1:0] nd_dec;

	assign fire       = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign accept     = item_valid && !item_stall;

	// take the next byte whenever the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= char_byte;
			eol_s1  <= end_of_line;
			base_s1 <= base_offset;
		end
	end

	// fresh line view
	always_comb begin
		md   = start_q ? MODE_BETWEEN : mode_q;
		cp   = start_q ? '0 : cp_q;
		ws   = start_q ? '0 : ws_q;
		nd   = start_q ? '0 : nd_q;
		base = start_q ? base_s1 : lbase_q;
	end

	// positions and word length
	assign abs_cp    = {2'b00, base} + {1'b0, cp};
	assign abs_ws    = POS_W'({1'b0, base} + ws);
	assign wlen      = cp - ws;
	assign long_word = wlen > POS_W'(LEN_MAX);
	assign is_space  = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB) ||
	                   (char_s1 == CH_CR) || (char_s1 == CH_LF);
	assign too_long  = (32'(cp) >= MAX_LINE_LEN) || (32'(abs_cp) >= POS_MAX);
	assign nd_dec    = nd - DEPTH_W'(1);

	always_comb begin
		word_res.last = 1'b1;
		if (long_word) begin
			word_res.kind = KIND_LONG;
			word_res.pos  = abs_cp[POS_W-1:0];
			word_res.len  = '0;
		end else begin
			word_res.kind = KIND_WORD;
			word_res.pos  = abs_ws;
			word_res.len  = wlen[LEN_W-1:0];
		end
	end

	// per-byte decision
	always_comb begin
		n       = 2'd0;
		r0      = '{kind: KIND_OK, pos: abs_cp[POS_W-1:0], len: '0, last: 1'b1};
		r1      = '{kind: KIND_OK, pos: abs_cp[POS_W-1:0], len: '0, last: 1'b1};
		mode_d  = md;
		cp_d    = cp;
		ws_d    = ws;
		nd_d    = nd;
		start_d = 1'b0;
		if (eol_s1) begin
			case (md)
				MODE_BETWEEN: begin
					n = 2'd1;
				end
				MODE_BARE: begin
					if (long_word) begin
						n  = 2'd1;
						r0 = word_res;
					end else begin
						n  = 2'd2;
						r0 = word_res;
						r0.last = 1'b0;
					end
				end
				MODE_BRACED: begin
					n       = 2'd1;
					r0.kind = KIND_END;
				end
				default: begin
					n = 2'd0;
				end
			endcase
			mode_d  = MODE_BETWEEN;
			nd_d    = '0;
			start_d = 1'b1;
		end else if (md == MODE_DROP) begin
			n = 2'd0;
		end else if (too_long) begin
			n       = 2'd1;
			r0.kind = KIND_LONG;
			mode_d  = MODE_DROP;
		end else begin
			cp_d = cp + POS_W'(1);
			case (md)
				MODE_BETWEEN: begin
					if (is_space) begin
						mode_d = MODE_BETWEEN;
					end else if (char_s1 == CH_HASH) begin
						n      = 2'd1;
						mode_d = MODE_DROP;
					end else if (char_s1 == CH_LBRACE) begin
						nd_d   = DEPTH_W'(1);
						ws_d   = cp + POS_W'(1);
						mode_d = MODE_BRACED;
					end else begin
						ws_d   = cp;
						mode_d = MODE_BARE;
					end
				end
				MODE_BARE: begin
					if (is_space) begin
						n      = 2'd1;
						r0     = word_res;
						mode_d = long_word ? MODE_DROP : MODE_BETWEEN;
					end else if ((char_s1 == CH_LBRACE) || (char_s1 == CH_RBRACE)) begin
						n       = 2'd1;
						r0.kind = KIND_BRACE;
						mode_d  = MODE_DROP;
					end
				end
				default: begin
					if (char_s1 == CH_LBRACE) begin
						if (32'(nd) >= MAX_NEST_DEPTH) begin
							n       = 2'd1;
							r0.kind = KIND_DEEP;
							mode_d  = MODE_DROP;
						end else begin
							nd_d = nd + DEPTH_W'(1);
						end
					end else if (char_s1 == CH_RBRACE) begin
						nd_d = nd_dec;
						if (nd_dec == '0) begin
							n      = 2'd1;
							r0     = word_res;
							mode_d = long_word ? MODE_DROP : MODE_BETWEEN;
						end
					end
				end
			endcase
		end
	end

	// state update when the byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			cp_q    <= '0;
			ws_q    <= '0;
			nd_q    <= '0;
			lbase_q <= '0;
			start_q <= 1'b1;
		end else if (fire) begin
			mode_q  <= mode_d;
			cp_q    <= cp_d;
			ws_q    <= ws_d;
			nd_q    <= nd_d;
			lbase_q <= base;
			start_q <= start_d;
		end
	end

	assign push.n  = fire ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

endmodule

>>> hw/rtl/bnwt_rqueue.sv
// result queue: small flop fifo taking up to two results a cycle
module bnwt_rqueue import bnwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	output logic              room,
	output logic [QCNT_W-1:0] fill,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [KIND_W-1:0] result_kind,
	output logic [POS_W-1:0]  position,
	output logic [LEN_W-1:0]  word_length,
	output logic              last_of_run
);

	res_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;
	logic [QCNT_W-1:0] after_pop;
	res_t              head;

	assign pop       = res_valid && !res_stall;
	assign after_pop = cnt_q - QCNT_W'(pop);
	// space for the worst case of two results
	assign room      = after_pop <= QCNT_W'(QDEPTH - 2);
	assign fill      = cnt_q;
	assign res_valid = cnt_q != '0;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.n);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= after_pop + QCNT_W'(push.n);
		end
	end

	// entry writes
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[wr_q + QPTR_W'(1)] <= push.r1;
		end
	end

	// head of queue onto the ports
	assign head        = entry_q[rd_q];
	assign result_kind = head.kind;
	assign position    = head.pos;
	assign word_length = head.len;
	assign last_of_run = head.last;

endmodule

>>> hw/rtl/brace_nested_word_tokenizer_unit.sv
// path: an accepted word is held in the scanner input register, and its results go through the result queue
// throughput: one input word per cycle while the queue has room; an end marker closing a bare word
//   gives two results, which the four-entry result queue takes together in the same cycle
// input stalls only while the result queue cannot take two more results
// reset: asynchronous, active low; clears the queue and opens a fresh line
`include "assert_macros.svh"
module brace_nested_word_tokenizer_unit import bnwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [CHAR_W-1:0] char_byte,
	input  logic              end_of_line,
	input  logic [BASE_W-1:0] base_offset,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [KIND_W-1:0] result_kind,
	output logic [POS_W-1:0]  position,
	output logic [LEN_W-1:0]  word_length,
	output logic              last_of_run
);

	push_t             push;
	logic              room;
	logic [QCNT_W-1:0] fill;

	// scanner
	bnwt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.char_byte   (char_byte),
		.end_of_line (end_of_line),
		.base_offset (base_offset),
		.room        (room),
		.push        (push)
	);

	// result queue
	bnwt_rqueue u_rqueue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.fill        (fill),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.result_kind (result_kind),
		.position    (position),
		.word_length (word_length),
		.last_of_run (last_of_run)
	);

	// checks
	`BNWT_ASSERT(a_fill_bound, fill <= QCNT_W'(QDEPTH), "result queue overfilled")
	`BNWT_ASSERT_IMP(a_pair_shape, push.n == 2'd2, (push.r0.kind == KIND_WORD) && (push.r1.kind == KIND_OK) && !push.r0.last && push.r1.last, "bad result pair")
	`BNWT_ASSERT_IMP(a_stall_cause, item_stall, res_valid && (fill > QCNT_W'(QDEPTH - 2)), "input stalled with queue room")
	`BNWT_ASSERT_IMP(a_single_last, push.n == 2'd1, push.r0.last, "single result without last mark")

endmodule

>>> tb/bnwt_checker.sv
// checker: tracks the tokenizer's channels, predicts each result word and compares
module bnwt_checker import bnwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  logic [CHAR_W-1:0] char_byte,
	input  logic              end_of_line,
	input  logic [BASE_W-1:0] base_offset,
	input  logic              res_valid,
	input  logic              res_stall,
	input  logic [KIND_W-1:0] result_kind,
	input  logic [POS_W-1:0]  position,
	input  logic [LEN_W-1:0]  word_length,
	input  logic              last_of_run,
	output int                fail_count,
	output int                pending,
	output int                words_in,
	output int                results_out
);
	timeunit 1ns;
	timeprecision 1ps;

	// scanner state of the prediction
	logic [1:0] scan_mode  = MODE_BETWEEN;
	logic       line_start = 1'b1;
	int         char_pos   = 0;
	int         word_start = 0;
	int         nest       = 0;
	int         line_base  = 0;

	// results still to come, oldest first
	res_t expected_tokens[$];
	res_t got;
	res_t want;

	function automatic res_t token_result(logic [KIND_W-1:0] kind, int pos, int len);
		res_t r;
		r.kind = kind;
		r.pos  = pos[POS_W-1:0];
		r.len  = len[LEN_W-1:0];
		r.last = 1'b1;
		return r;
	endfunction

	function automatic bit is_blank(logic [CHAR_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	// word ending at the current position, or a too-long error in its place
	function automatic res_t close_word(output bit fits);
		int len;
		len = char_pos - word_start;
		fits = (len <= LEN_MAX);
		if (!fits)
			return token_result(KIND_LONG, line_base + char_pos, 0);
		return token_result(KIND_WORD, line_base + word_start, len);
	endfunction

	// advance the scanner by one input word and queue what it yields
	function automatic void tokenise_byte(logic [CHAR_W-1:0] c, logic eol,
			logic [BASE_W-1:0] base);
		res_t found[2];
		int   n;
		int   here;
		bit   fits;
		n = 0;
		fits = 1'b1;
		// fresh line picks up its base
		if (line_start) begin
			line_base  = base;
			char_pos   = 0;
			word_start = 0;
			nest       = 0;
			scan_mode  = MODE_BETWEEN;
			line_start = 1'b0;
		end
		here = line_base + char_pos;
		if (eol) begin
			case (scan_mode)
				MODE_BETWEEN: begin
					found[0] = token_result(KIND_OK, here, 0);
					n = 1;
				end
				MODE_BARE: begin
					found[0] = close_word(fits);
					n = 1;
					if (fits) begin
						found[1] = token_result(KIND_OK, here, 0);
						n = 2;
					end
				end
				MODE_BRACED: begin
					found[0] = token_result(KIND_END, here, 0);
					n = 1;
				end
				default: ;
			endcase
			scan_mode  = MODE_BETWEEN;
			nest       = 0;
			line_start = 1'b1;
		end else if (scan_mode != MODE_DROP) begin
			if (char_pos >= MAX_LINE_LEN || here >= POS_MAX) begin
				// line has run out of room
				found[0] = token_result(KIND_LONG, here, 0);
				n = 1;
				scan_mode = MODE_DROP;
			end else begin
				case (scan_mode)
					MODE_BETWEEN: begin
						if (c == CH_HASH) begin
							found[0] = token_result(KIND_OK, here, 0);
							n = 1;
							scan_mode = MODE_DROP;
						end else if (c == CH_LBRACE) begin
							nest       = 1;
							word_start = char_pos + 1;
							scan_mode  = MODE_BRACED;
						end else if (!is_blank(c)) begin
							word_start = char_pos;
							scan_mode  = MODE_BARE;
						end
					end
					MODE_BARE: begin
						if (is_blank(c)) begin
							found[0] = close_word(fits);
							n = 1;
							scan_mode = fits ? MODE_BETWEEN : MODE_DROP;
						end else if (c == CH_LBRACE || c == CH_RBRACE) begin
							found[0] = token_result(KIND_BRACE, here, 0);
							n = 1;
							scan_mode = MODE_DROP;
						end
					end
					default: begin
						if (c == CH_LBRACE) begin
							if (nest >= MAX_NEST_DEPTH) begin
								found[0] = token_result(KIND_DEEP, here, 0);
								n = 1;
								scan_mode = MODE_DROP;
							end else begin
								nest++;
							end
						end else if (c == CH_RBRACE) begin
							nest--;
							if (nest == 0) begin
								found[0] = close_word(fits);
								n = 1;
								scan_mode = fits ? MODE_BETWEEN : MODE_DROP;
							end
						end
					end
				endcase
				char_pos++;
			end
		end
		for (int i = 0; i < n; i++) begin
			found[i].last = (i == n - 1);
			expected_tokens.push_back(found[i]);
		end
	endfunction

	task automatic report_field(string field, int wanted, int seen);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, wanted, seen);
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode   = MODE_BETWEEN;
			line_start  = 1'b1;
			char_pos    = 0;
			word_start  = 0;
			nest        = 0;
			line_base   = 0;
			expected_tokens.delete();
			fail_count  = 0;
			pending     = 0;
			words_in    = 0;
			results_out = 0;
		end else begin
			// result word taken by the receiver
			if (res_valid && !res_stall) begin
				results_out++;
				got = {result_kind, position, word_length, last_of_run};
				if (expected_tokens.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result, kind %0d pos %0d len %0d last %0d",
						$time, got.kind, got.pos, got.len, got.last);
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind)
						report_field("result_kind", want.kind, got.kind);
					if (got.pos !== want.pos)
						report_field("position", want.pos, got.pos);
					if (got.len !== want.len)
						report_field("word_length", want.len, got.len);
					if (got.last !== want.last)
						report_field("last_of_run", want.last, got.last);
				end
			end
			// input word taken by the block
			if (item_valid && !item_stall) begin
				words_in++;
				tokenise_byte(char_byte, end_of_line, base_offset);
			end
			pending = expected_tokens.size();
		end
	end

endmodule

>>> tb/testbench.sv
// testbench top: feeds lines of text to the tokenizer and gives the verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bnwt_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [CHAR_W-1:0] char_byte = '0;
	logic              end_of_line = 1'b0;
	logic [BASE_W-1:0] base_offset = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [KIND_W-1:0] result_kind;
	logic [POS_W-1:0]  position;
	logic [LEN_W-1:0]  word_length;
	logic              last_of_run;

	int fail_count;
	int pending;
	int words_in;
	int results_out;

	// sender and receiver pacing
	int burst_left   = 0;
	int random_words = 0;
	int lines_sent   = 0;
	int stall_mode   = 0;
	int phase_left   = 0;
	int run_left     = 0;
	bit run_high     = 1'b0;

	logic [CHAR_W-1:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

	brace_nested_word_tokenizer_unit i_dut (.*);

	bnwt_checker i_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stall pattern: free, sparse, or long runs, in phases
	always @(posedge clk) begin
		if (phase_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			phase_left = $urandom_range(50, 300);
		end
		phase_left--;
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (run_left == 0) begin
					run_high = !run_high;
					run_left = run_high ? $urandom_range(1, 8) : $urandom_range(1, 12);
				end
				run_left--;
				res_stall <= run_high;
			end
		endcase
	end

	function automatic logic [BASE_W-1:0] rand_base();
		return BASE_W'($urandom);
	endfunction

	function automatic logic [CHAR_W-1:0] noise_char();
		return CHAR_W'($urandom);
	endfunction

	// any byte that keeps a bare word going
	function automatic logic [CHAR_W-1:0] word_char();
		logic [CHAR_W-1:0] c;
		do
			c = noise_char();
		while (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
			c == CH_HASH || c == CH_LBRACE || c == CH_RBRACE);
		return c;
	endfunction

	// one input word, in bursts with random gaps
	task automatic send_item(logic [CHAR_W-1:0] c, logic eol, logic [BASE_W-1:0] base,
			bit counted);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid  <= 1'b1;
		char_byte   <= c;
		end_of_line <= eol;
		base_offset <= base;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (counted)
			random_words++;
	endtask

	// text then the end marker; only the first word carries the line base
	task automatic send_line(string text, logic [BASE_W-1:0] base);
		for (int i = 0; i < text.len(); i++)
			send_item(text[i], 1'b0, (i == 0) ? base : rand_base(), 1'b0);
		send_item(noise_char(), 1'b1, (text.len() == 0) ? base : rand_base(), 1'b0);
	endtask

	task automatic send_repeat(logic [CHAR_W-1:0] c, int count, logic [BASE_W-1:0] base);
		for (int i = 0; i < count; i++)
			send_item(c, 1'b0, (i == 0) ? base : rand_base(), 1'b0);
	endtask

	// hold the sender until every expected result has come out
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// mostly well-formed words with random content, some broken pieces and noise
	task automatic send_random_line();
		int tokens;
		int pick;
		int depth;
		int step;
		bit broken;
		tokens = $urandom_range(0, 6);
		broken = 1'b0;
		for (int t = 0; t < tokens && !broken; t++) begin
			repeat ($urandom_range(0, 3))
				send_item(blanks[$urandom_range(0, 3)], 1'b0, rand_base(), 1'b1);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				repeat ($urandom_range(1, 8))
					send_item(word_char(), 1'b0, rand_base(), 1'b1);
			end else if (pick < 75) begin
				// braced word nested a few levels
				send_item(CH_LBRACE, 1'b0, rand_base(), 1'b1);
				depth = 1;
				repeat ($urandom_range(0, 12)) begin
					step = $urandom_range(0, 9);
					if (step < 2 && depth < 4) begin
						send_item(CH_LBRACE, 1'b0, rand_base(), 1'b1);
						depth++;
					end else if (step < 4 && depth > 1) begin
						send_item(CH_RBRACE, 1'b0, rand_base(), 1'b1);
						depth--;
					end else if (step < 6) begin
						send_item(blanks[$urandom_range(0, 3)], 1'b0, rand_base(), 1'b1);
					end else begin
						send_item(word_char(), 1'b0, rand_base(), 1'b1);
					end
				end
				repeat (depth)
					send_item(CH_RBRACE, 1'b0, rand_base(), 1'b1);
			end else if (pick < 80) begin
				// comment, the rest is dropped
				send_item(CH_HASH, 1'b0, rand_base(), 1'b1);
				repeat ($urandom_range(0, 5))
					send_item(noise_char(), 1'b0, rand_base(), 1'b0);
				broken = 1'b1;
			end else if (pick < 86) begin
				// brace inside a bare word
				repeat ($urandom_range(1, 4))
					send_item(word_char(), 1'b0, rand_base(), 1'b1);
				send_item($urandom_range(0, 1) ? CH_LBRACE : CH_RBRACE, 1'b0,
					rand_base(), 1'b1);
				repeat ($urandom_range(0, 5))
					send_item(noise_char(), 1'b0, rand_base(), 1'b0);
				broken = 1'b1;
			end else if (pick < 91) begin
				// brace left open at the end of the line
				send_item(CH_LBRACE, 1'b0, rand_base(), 1'b1);
				repeat ($urandom_range(0, 5))
					send_item(word_char(), 1'b0, rand_base(), 1'b1);
				broken = 1'b1;
			end else begin
				send_item(noise_char(), 1'b0, rand_base(), 1'b1);
			end
		end
		send_item(noise_char(), 1'b1, rand_base(), 1'b1);
		lines_sent++;
	endtask

	// stimulus and verdict
	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines: empty, bare, braced, comments and brace errors
		send_line("", 10'd0);
		send_line("word", 10'd1023);
		send_line(" {a {b} c}\t{}\015x\ny # junk {", 10'd5);
		send_line("#", 10'd7);
		send_line("a{b", 10'd0);
		send_line("ab} c", 10'd200);
		send_line("{ab{c}", 10'd300);
		send_line("}x {}}", 10'd400);
		// byte extremes inside words
		send_item(8'h00, 1'b0, 10'd0, 1'b0);
		send_item(8'hFF, 1'b0, 10'd1023, 1'b0);
		send_item(CH_TAB, 1'b0, 10'd0, 1'b0);
		send_item(8'h80, 1'b0, 10'd0, 1'b0);
		send_line("", rand_base());
		// word one past the length limit, closed by the end marker
		send_repeat("a", 1024, 10'd0);
		send_line("", rand_base());
		// line running past its room, rest dropped
		send_repeat("b", 1025, 10'd1023);
		send_line("d", rand_base());
		// nesting one too deep, then the deepest that fits
		send_repeat(CH_LBRACE, 256, 10'd17);
		send_line("", rand_base());
		send_repeat(CH_LBRACE, 255, 10'd600);
		send_repeat(CH_RBRACE, 255, rand_base());
		send_line("", rand_base());
		wait_drained();

		// random lines
		while (random_words < 900) begin
			send_random_line();
			if ($urandom_range(0, 39) == 0)
				wait_drained();
		end
		wait_drained();
		repeat (20) @(posedge clk);
		@(negedge clk);

		$display("%0d input words accepted, %0d random lines, %0d results checked",
			words_in, lines_sent, results_out);
		$display("covered bare, braced and nested words, comments, brace errors, open braces,"
			, " long lines, long words and deep nesting");
		if (fail_count == 0 && pending == 0) begin
			$display("[brace_nested_word_tokenizer_unit] OK");
		end else begin
			$display("[brace_nested_word_tokenizer_unit] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#4000000;
		$display("[brace_nested_word_tokenizer_unit] ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bnwt_pkg.sv
hw/rtl/bnwt_scan.sv
hw/rtl/bnwt_rqueue.sv
hw/rtl/brace_nested_word_tokenizer_unit.sv
tb/bnwt_checker.sv
tb/testbench.sv
